/* design/positional_insert_delete_list_unit_assert.svh */
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit assertion macros
// Concurrent checks used by the list unit; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PIDL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidl assertion failed");
// next-cycle implication
`define PIDL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidl assertion failed");
`else
`define PIDL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIDL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/pidl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and codes of the positional insert/delete list unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

    // request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // reply status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_PUT,
        S_REPLY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the input beat
        logic start;   // set up the shift sweep
        logic shift;   // run one step of the sweep
        logic put;     // write the inserted value
        logic finish;  // load the reply register, update length
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic err;         // request rejected
        logic is_insert;   // captured request is an insert
        logic shift_done;  // sweep has no read left in flight
        logic out_busy;    // reply register full and stalled
    } stat_t;

endpackage

/* design/pidl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pidl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_ctrl
// Sequencer: accepts a request, runs the shift sweep, issues the reply.
// ----------------------------------------------------------------------------
`include "positional_insert_delete_list_unit_assert.svh"

module pidl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output pidl_pkg::cmd_t  cmd,
    input  pidl_pkg::stat_t stat
);

    pidl_pkg::state_t state_reg;
    pidl_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != pidl_pkg::S_IDLE);
        case (state_reg)
            pidl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pidl_pkg::S_CHECK;
                end
            end
            pidl_pkg::S_CHECK:
            begin
                if (stat.err)
                begin
                    state_next = pidl_pkg::S_REPLY;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = pidl_pkg::S_SHIFT;
                end
            end
            pidl_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = stat.is_insert ? pidl_pkg::S_PUT : pidl_pkg::S_REPLY;
                end
            end
            pidl_pkg::S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = pidl_pkg::S_REPLY;
            end
            pidl_pkg::S_REPLY:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = pidl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pidl_pkg::S_IDLE;
            end
        endcase
    end

    // reply never overwrites a held result
    `PIDL_ASSERT_IMP(a_finish_free, clk, rst_n, cmd.finish, !stat.out_busy)
    // value write only for an accepted insert
    `PIDL_ASSERT_IMP(a_put_ok, clk, rst_n, cmd.put, stat.is_insert && !stat.err)
    // a rejected request skips the sweep
    `PIDL_ASSERT_NXT(a_err_reply, clk, rst_n,
        (state_reg == pidl_pkg::S_CHECK) && stat.err, state_reg == pidl_pkg::S_REPLY)

endmodule

/* design/pidl_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_dpath
// Request registers, range checks, length counter, shift sweep over the
// entry memory and the reply register.
// ----------------------------------------------------------------------------
`include "positional_insert_delete_list_unit_assert.svh"

module pidl_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pidl_pkg::cmd_t          cmd,
    output pidl_pkg::stat_t         stat,
    input  logic                    operation,
    input  logic [6:0]              position,
    input  logic signed [31:0]      value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      removed_value,
    output logic [6:0]              list_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;

    // request
    logic                  op_reg;
    logic [6:0]            pos_reg;
    logic [31:0]           val_reg;

    // control state
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic                  pend_reg, pend_next;
    logic                  first_reg, first_next;
    logic                  out_valid_reg, out_valid_next;

    // sweep addresses and captured data
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic [31:0]           removed_reg, removed_next;

    // reply
    pidl_pkg::status_t     status_reg;
    logic [31:0]           rmv_out_reg;
    logic [6:0]            len_reg;

    // checks
    logic [PW-1:0]         pos_x, cnt_x, cap_x, n_x, cnt_new_x;
    logic [AW-1:0]         idx;
    pidl_pkg::status_t     chk_status;
    logic                  is_ins, ok;

    // memory port
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_wa;
    logic [31:0]           ram_wd, ram_rd;
    logic                  issue, shift_wr;

    // range checks on the captured request
    always_comb
    begin
        pos_x  = PW'(pos_reg);
        cnt_x  = PW'(count_reg);
        cap_x  = PW'(CAPACITY);
        is_ins = (op_reg == pidl_pkg::OP_INSERT);
        idx    = AW'(pos_x - PW'(1));
        n_x    = cnt_x - pos_x + PW'(1);
        if (is_ins)
        begin
            if ((pos_x == '0) || (pos_x > cnt_x + PW'(1)))
                chk_status = pidl_pkg::ST_BADPOS;
            else if (cnt_x >= cap_x)
                chk_status = pidl_pkg::ST_FULL;
            else
                chk_status = pidl_pkg::ST_OK;
        end
        else
        begin
            if ((pos_x == '0) || (pos_x > cnt_x))
                chk_status = pidl_pkg::ST_BADPOS;
            else
                chk_status = pidl_pkg::ST_OK;
        end
        ok = (chk_status == pidl_pkg::ST_OK);
        if (!ok)
            cnt_new_x = cnt_x;
        else if (is_ins)
            cnt_new_x = cnt_x + PW'(1);
        else
            cnt_new_x = cnt_x - PW'(1);
    end

    // shift sweep: one read issued and one write retired per cycle
    always_comb
    begin
        issue        = cmd.shift && (rem_reg != '0);
        shift_wr     = cmd.shift && pend_reg && !(!is_ins && first_reg);
        rem_next     = rem_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = 1'b0;
        first_next   = first_reg;
        removed_next = removed_reg;
        if (cmd.start)
        begin
            rem_next     = CW'(n_x);
            rd_addr_next = is_ins ? AW'(cnt_x - PW'(1)) : idx;
            first_next   = 1'b1;
            removed_next = '0;
        end
        else
        begin
            if (issue)
            begin
                rem_next     = rem_reg - CW'(1);
                rd_addr_next = is_ins ? rd_addr_reg - AW'(1) : rd_addr_reg + AW'(1);
                wr_addr_next = is_ins ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                pend_next    = 1'b1;
            end
            if (cmd.shift && pend_reg)
            begin
                first_next = 1'b0;
                if (!is_ins && first_reg)
                    removed_next = ram_rd;
            end
        end
    end

    // memory write select
    always_comb
    begin
        ram_re = issue;
        ram_we = shift_wr || cmd.put;
        ram_wa = cmd.put ? idx : wr_addr_reg;
        ram_wd = cmd.put ? val_reg : ram_rd;
    end

    pidl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .re      (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd)
    );

    // length and reply valid
    always_comb
    begin
        count_next     = cmd.finish ? CW'(cnt_new_x) : count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= value;
        end
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        removed_reg <= removed_next;
        if (cmd.finish)
        begin
            status_reg  <= chk_status;
            rmv_out_reg <= (ok && !is_ins) ? removed_reg : '0;
            len_reg     <= 7'(cnt_new_x);
        end
    end

    // status to controller
    always_comb
    begin
        stat.err        = !ok;
        stat.is_insert  = is_ins;
        stat.shift_done = (rem_reg == '0) && !pend_reg;
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = rmv_out_reg;
    assign list_length   = len_reg;

    // length stays within the store
    `PIDL_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, cnt_x <= cap_x)
    // sweep never writes the address it reads in the same cycle
    `PIDL_ASSERT_IMP(a_rw_apart, clk, rst_n, ram_we && ram_re, ram_wa != rd_addr_reg)
    // the value write and a sweep write never collide
    `PIDL_ASSERT_IMP(a_put_alone, clk, rst_n, cmd.put, !shift_wr && !issue)

endmodule

/* design/positional_insert_delete_list_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Ordered list of signed 32-bit values with positional insert and delete.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | operation, position, value
//   out     | output    | out_valid/out_stall| status, removed_value, list_length
//
// An insert or delete runs a sweep over n entries, n being length - position + 1,
// then an insert writes its value; the sweep reads one entry and writes one entry
// of the memory per cycle. A rejected request skips the sweep.
// Reset clears the length; entry contents need no clearing.
// A finished result waits in the output register while the next request is taken;
// a request completes only once that register is free.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [6:0]         list_length
);

    pidl_pkg::cmd_t  cmd;
    pidl_pkg::stat_t stat;

    // sequencer
    pidl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath with entry memory
    pidl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .list_length   (list_length)
    );

endmodule

/* sim/positional_insert_delete_list_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit_tb
// Self-checking bench for the positional insert/delete list unit. A queue of
// requests feeds a falling-edge driver; each accepted request runs through a
// shadow list that yields the expected reply, and a rising-edge monitor
// compares every reply beat field by field. Phases vary sender idling and
// receiver stalls, and one phase holds the receiver off to back up the unit.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit_tb;

    localparam int LIST_CAP    = 64;
    localparam int PHASE_ITEMS = 205;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic               operation;
        logic [6:0]         position;
        logic signed [31:0] value;
    } list_req_t;

    typedef struct packed {
        pidl_pkg::status_t  status;
        logic signed [31:0] removed_value;
        logic [6:0]         list_length;
    } list_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               operation = 1'b0;
    logic [6:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         list_length;

    // request and reply stores
    list_req_t   req_pending[$];
    list_reply_t reply_expected[$];

    // shadow copy of the list
    logic signed [31:0] shadow_entries[LIST_CAP];
    int                 shadow_len = 0;

    // stimulus planning state (length as the queued requests will leave it)
    int plan_len = 0;
    bit growing = 1'b1;
    int edge_streak = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int err_cnt = 0;
    bit in_taken = 1'b0;

    positional_insert_delete_list_unit #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .position     (position),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .removed_value(removed_value),
        .list_length  (list_length)
    );

    always #1 clk = ~clk;

    // apply one request to the shadow list and return the reply it causes
    function automatic list_reply_t predict_reply(list_req_t rq);
        list_reply_t rp;
        int          p;
        int          k;
        rp.status        = pidl_pkg::ST_OK;
        rp.removed_value = '0;
        p = rq.position;
        if (rq.operation == pidl_pkg::OP_INSERT)
        begin
            if (p < 1 || p > shadow_len + 1)
                rp.status = pidl_pkg::ST_BADPOS;
            else if (shadow_len >= LIST_CAP)
                rp.status = pidl_pkg::ST_FULL;
            else
            begin
                for (k = shadow_len; k > p - 1; k--)
                    shadow_entries[k] = shadow_entries[k - 1];
                shadow_entries[p - 1] = rq.value;
                shadow_len++;
            end
        end
        else
        begin
            if (p < 1 || p > shadow_len)
                rp.status = pidl_pkg::ST_BADPOS;
            else
            begin
                rp.removed_value = shadow_entries[p - 1];
                for (k = p; k < shadow_len; k++)
                    shadow_entries[k - 1] = shadow_entries[k];
                shadow_len--;
            end
        end
        rp.list_length = shadow_len[6:0];
        return rp;
    endfunction

    // queue one request and track the length it will leave
    task automatic queue_req(logic op, logic [6:0] pos, logic signed [31:0] val);
        list_req_t rq;
        rq.operation = op;
        rq.position  = pos;
        rq.value     = val;
        req_pending.push_back(rq);
        if (op == pidl_pkg::OP_INSERT)
        begin
            if (pos >= 1 && pos <= plan_len + 1 && plan_len < LIST_CAP)
                plan_len++;
        end
        else if (pos >= 1 && pos <= plan_len)
            plan_len--;
    endtask

    // random requests: mostly valid positions, sweeping the list between
    // empty and full, with some out-of-range positions mixed in
    task automatic queue_random(int n);
        logic               op;
        logic [6:0]         pos;
        logic signed [31:0] val;
        int                 lim;
        int                 r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (growing)
                op = (r < 75) ? pidl_pkg::OP_INSERT : pidl_pkg::OP_DELETE;
            else
                op = (r < 75) ? pidl_pkg::OP_DELETE : pidl_pkg::OP_INSERT;
            lim = (op == pidl_pkg::OP_INSERT) ? plan_len + 1 : plan_len;
            if (op == pidl_pkg::OP_INSERT && lim > LIST_CAP)
                lim = LIST_CAP + 1;
            r = $urandom_range(99);
            if (r < 10 || lim == 0)
                pos = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, lim + 1));
            else if (r < 20)
                pos = $urandom_range(1) ? 7'd1 : 7'(lim);
            else
                pos = 7'($urandom_range(lim, 1));
            case ($urandom_range(19))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = 32'sh0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            queue_req(op, pos, val);
            // turn around after dwelling a little at full or empty
            if ((growing && plan_len == LIST_CAP) || (!growing && plan_len == 0))
            begin
                edge_streak++;
                if (edge_streak > 6)
                begin
                    growing     = ~growing;
                    edge_streak = 0;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || reply_expected.size() != 0)
            @(posedge clk);
    endtask

    // input acceptance: predict at the edge where the beat is taken
    always @(posedge clk)
    begin
        in_taken = in_valid && !in_stall;
        if (in_taken)
        begin
            reply_expected.push_back(predict_reply(req_pending[0]));
            void'(req_pending.pop_front());
        end
    end

    // input driver: hold an offered beat until taken, else maybe offer the next
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                operation <= req_pending[0].operation;
                position  <= req_pending[0].position;
                value     <= req_pending[0].value;
            end
            else
            begin
                // idle: junk on the payload, which must be ignored
                in_valid  <= 1'b0;
                operation <= $urandom_range(1);
                position  <= $urandom_range(127);
                value     <= $urandom;
            end
        end
    end

    // receiver stall, with a counted long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // reply monitor
    always @(posedge clk)
    begin
        list_reply_t exp_rp;
        if (out_valid && !out_stall)
        begin
            if (reply_expected.size() == 0)
            begin
                $error("reply beat with no request outstanding");
                err_cnt++;
            end
            else
            begin
                exp_rp = reply_expected.pop_front();
                if (status !== exp_rp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rp.status, status);
                    err_cnt++;
                end
                if (removed_value !== exp_rp.removed_value)
                begin
                    $error("removed_value: expected %0d, got %0d",
                           exp_rp.removed_value, removed_value);
                    err_cnt++;
                end
                if (list_length !== exp_rp.list_length)
                begin
                    $error("list_length: expected %0d, got %0d",
                           exp_rp.list_length, list_length);
                    err_cnt++;
                end
            end
        end
    end

    // stimulus and phase control
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, bad positions, ends and middle, extremes
        queue_req(pidl_pkg::OP_DELETE, 7'd1,   32'sh1234_5678);
        queue_req(pidl_pkg::OP_DELETE, 7'd0,   32'sh0);
        queue_req(pidl_pkg::OP_INSERT, 7'd0,   32'sh1);
        queue_req(pidl_pkg::OP_INSERT, 7'd2,   32'sh2);
        queue_req(pidl_pkg::OP_INSERT, 7'd127, 32'sh3);
        queue_req(pidl_pkg::OP_INSERT, 7'd1,   32'sh8000_0000);
        queue_req(pidl_pkg::OP_INSERT, 7'd2,   32'sh7fff_ffff);
        queue_req(pidl_pkg::OP_INSERT, 7'd1,   -32'sd1);
        queue_req(pidl_pkg::OP_INSERT, 7'd2,   32'sh0);
        queue_req(pidl_pkg::OP_INSERT, 7'd6,   32'sh4);
        queue_req(pidl_pkg::OP_DELETE, 7'd5,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd4,   32'shffff_ffff);
        queue_req(pidl_pkg::OP_DELETE, 7'd1,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd0,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd127, 32'sh0);
        queue_req(pidl_pkg::OP_INSERT, 7'd3,   32'sh5555_5555);
        queue_req(pidl_pkg::OP_DELETE, 7'd2,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd1,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd1,   32'sh0);
        queue_req(pidl_pkg::OP_DELETE, 7'd1,   32'sh0);
        wait_drained();

        // no idling
        queue_random(PHASE_ITEMS);
        wait_drained();

        // sender idles often
        send_idle_pct = 61;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // receiver stalls often
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // both sides idle
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0 && reply_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/pidl_pkg.sv
design/pidl_ram.sv
design/pidl_ctrl.sv
design/pidl_dpath.sv
design/positional_insert_delete_list_unit.sv
sim/positional_insert_delete_list_unit_tb.sv
